FILE: sv/mtig_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the mesh triangle index generator
// no dependencies; used by the top level, the front, the back and the bench

package mtig_pkg;

  // configuration field widths and port geometry
  localparam int CFG_W   = 9;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;
  localparam int ARITH_W = 32;
  localparam int PROD_W  = 2 * CFG_W;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // shape mode codes
  localparam logic [1:0] MODE_GRID = 2'd0;
  localparam logic [1:0] MODE_TUBE = 2'd1;
  localparam logic [1:0] MODE_FAN  = 2'd2;

  // register index codes (byte address bits [4:2])
  localparam logic [2:0] REG_SHAPE_MODE   = 3'd0;
  localparam logic [2:0] REG_COLUMNS      = 3'd1;
  localparam logic [2:0] REG_ROWS         = 3'd2;
  localparam logic [2:0] REG_CLOCKWISE    = 3'd3;
  localparam logic [2:0] REG_TRACK_OFFSET = 3'd4;

  typedef enum logic [1:0] {
    JOB_GRID,
    JOB_SEAM,
    JOB_FAN,
    JOB_EMPTY
  } job_kind_t;

  typedef struct packed {
    logic [1:0]       shape_mode;
    logic [CFG_W-1:0] columns;
    logic [CFG_W-1:0] rows;
    logic             clockwise;
    logic             track_offset;
  } cfg_t;

  // one triangle job handed from the front to the back
  typedef struct packed {
    job_kind_t        kind;
    logic             half;
    logic [CFG_W-1:0] col;
    logic [CFG_W-1:0] row;
    logic [CFG_W-1:0] cols;
    logic             last;
    logic             cw;
  } job_t;

endpackage

FILE: sv/mesh_triangle_index_generator.sv
`timescale 1ns / 1ps
// top level of the mesh triangle index generator: config registers,
// front walker, job queue and index back end; uses mtig_pkg and all submodules
//
//  channel   direction  handshake             payload
//  in_       input      in_valid / in_stall   in_action, in_start_offset
//  out_      output     out_valid / out_stall index first/second/third, shape_done,
//                                             empty_shape
//  config    input      psel/penable/pwrite   paddr, pwdata, prdata, pready
//
// one item per cycle while in_stall is low; an emit request's result is written
// into the queue at the edge that takes it, then passes the product stage and
// then the output register
// a load request (action 1) updates the running offset and gives no result
// the front updates the counters as each item is taken; the back needs one
// 9x9 product per triangle, kept in its own stage
// reset (synchronous, rst_n low) clears counters, offset, queue and pipeline
// and loads the register defaults
// in_stall rises only when the four-entry job queue is full; out_stall
// back-pressures the output register, then the product stage, then the queue

module mesh_triangle_index_generator #(
  parameter int MAX_POINTS = 256,
  parameter int INDEX_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic [INDEX_BITS-1:0]         in_start_offset,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [INDEX_BITS-1:0]         out_index_first,
  output logic [INDEX_BITS-1:0]         out_index_second,
  output logic [INDEX_BITS-1:0]         out_index_third,
  output logic                          out_shape_done,
  output logic                          out_empty_shape,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtig_pkg::ADDR_W-1:0]   paddr,
  input  logic [mtig_pkg::DATA_W-1:0]   pwdata,
  output logic [mtig_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int JOB_W = $bits(mtig_pkg::job_t);
  localparam int QW    = JOB_W + INDEX_BITS;
  localparam int CW    = mtig_pkg::CFG_W;
  localparam int DW    = mtig_pkg::DATA_W;

  mtig_pkg::cfg_t cfg_r;
  logic           cfg_wr;
  logic [2:0]     reg_sel;

  // front to queue
  logic                  q_full;
  logic                  push;
  mtig_pkg::job_t        push_job;
  logic [INDEX_BITS-1:0] push_off;

  // queue to back
  logic                  q_valid;
  logic                  pop;
  logic [QW-1:0]         q_data;
  mtig_pkg::job_t        q_job;
  logic [INDEX_BITS-1:0] q_off;

  // register file: writes complete in the access phase, no wait states
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.shape_mode   <= mtig_pkg::MODE_GRID;
      cfg_r.columns      <= CW'(2);
      cfg_r.rows         <= CW'(2);
      cfg_r.clockwise    <= 1'b1;
      cfg_r.track_offset <= 1'b0;
    end else if (cfg_wr) begin
      case (reg_sel)
        mtig_pkg::REG_SHAPE_MODE:   cfg_r.shape_mode   <= pwdata[1:0];
        mtig_pkg::REG_COLUMNS:      cfg_r.columns      <= pwdata[CW-1:0];
        mtig_pkg::REG_ROWS:         cfg_r.rows         <= pwdata[CW-1:0];
        mtig_pkg::REG_CLOCKWISE:    cfg_r.clockwise    <= pwdata[0];
        mtig_pkg::REG_TRACK_OFFSET: cfg_r.track_offset <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  // read-back mux, unmapped addresses read zero
  always_comb begin
    case (reg_sel)
      mtig_pkg::REG_SHAPE_MODE:   prdata = DW'(cfg_r.shape_mode);
      mtig_pkg::REG_COLUMNS:      prdata = DW'(cfg_r.columns);
      mtig_pkg::REG_ROWS:         prdata = DW'(cfg_r.rows);
      mtig_pkg::REG_CLOCKWISE:    prdata = DW'(cfg_r.clockwise);
      mtig_pkg::REG_TRACK_OFFSET: prdata = DW'(cfg_r.track_offset);
      default:                    prdata = '0;
    endcase
  end

  // front: classifies each item and advances the shape walk
  mtig_front #(
    .MAX_POINTS (MAX_POINTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .in_valid        (in_valid),
    .in_action       (in_action),
    .in_start_offset (in_start_offset),
    .in_stall        (in_stall),
    .q_full          (q_full),
    .push            (push),
    .push_job        (push_job),
    .push_off        (push_off)
  );

  // job queue so the walker keeps going while the output is held
  mtig_queue #(
    .WIDTH (QW),
    .DEPTH (mtig_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_off, push_job}),
    .full      (q_full),
    .pop       (pop),
    .pop_valid (q_valid),
    .pop_data  (q_data)
  );

  assign q_job = q_data[JOB_W-1:0];
  assign q_off = q_data[QW-1:JOB_W];

  // back: index arithmetic and result register
  mtig_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_job            (q_job),
    .q_off            (q_off),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_index_first  (out_index_first),
    .out_index_second (out_index_second),
    .out_index_third  (out_index_third),
    .out_shape_done   (out_shape_done),
    .out_empty_shape  (out_empty_shape)
  );

endmodule

FILE: sv/mtig_queue.sv
`timescale 1ns / 1ps
// small register fifo that decouples the front walker from the index back end
// generic, no package dependency

module mtig_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             pop_valid,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push || pop)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> !pop)
    else $error("queue pop while empty");

endmodule

FILE: sv/mtig_front.sv
`timescale 1ns / 1ps
// front end: accepts items, walks the shape counters and the running offset,
// and queues one triangle job per emit request; uses mtig_pkg

module mtig_front #(
  parameter int MAX_POINTS = 256,
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mtig_pkg::cfg_t        cfg,
  input  logic                  in_valid,
  input  logic                  in_action,
  input  logic [INDEX_BITS-1:0] in_start_offset,
  output logic                  in_stall,
  input  logic                  q_full,
  output logic                  push,
  output mtig_pkg::job_t        push_job,
  output logic [INDEX_BITS-1:0] push_off
);

  localparam int CW = mtig_pkg::CFG_W;
  localparam int CW_MAX = (1 << CW) - 1;
  localparam logic [CW-1:0] MAX_CLAMP =
    (MAX_POINTS > CW_MAX) ? CW'(CW_MAX) : CW'(MAX_POINTS);

  logic [CW-1:0]         cc_r, cc_nxt;
  logic [CW-1:0]         rc_r, rc_nxt;
  logic                  sh_r, sh_nxt;
  logic                  sp_r, sp_nxt;
  logic [INDEX_BITS-1:0] ro_r, ro_nxt;

  logic [CW-1:0]                   cols_c, rws_c;
  logic                            fan, tube, empty;
  logic                            accept, emit, load;
  logic                            col_end, row_end, last, end_sh, grid_end;
  logic [mtig_pkg::PROD_W-1:0]     area;
  logic [mtig_pkg::ARITH_W-1:0]    vcount;
  logic [INDEX_BITS-1:0]           ro_adv;

  assign cols_c = (cfg.columns > MAX_CLAMP) ? MAX_CLAMP : cfg.columns;
  assign rws_c  = (cfg.rows > MAX_CLAMP) ? MAX_CLAMP : cfg.rows;
  assign fan    = (cfg.shape_mode == mtig_pkg::MODE_FAN);
  assign tube   = (cfg.shape_mode == mtig_pkg::MODE_TUBE);

  always_comb begin
    if (fan) begin
      empty = (cols_c < CW'(2));
    end else if (tube) begin
      empty = (rws_c < CW'(2));
    end else begin
      empty = (cols_c < CW'(2)) || (rws_c < CW'(2));
    end
  end

  // vertex count of the shape, added to the running offset at shape end when tracking
  assign area   = {{CW{1'b0}}, cols_c} * {{CW{1'b0}}, rws_c};
  assign vcount = fan ? mtig_pkg::ARITH_W'(cols_c) + mtig_pkg::ARITH_W'(1)
                      : mtig_pkg::ARITH_W'(area);
  assign ro_adv = ro_r + vcount[INDEX_BITS-1:0];

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign emit     = accept && !in_action;
  assign load     = accept && in_action;
  assign push     = emit;
  assign push_off = cfg.track_offset ? ro_r : '0;

  assign col_end = ({1'b0, cc_r} + (CW+1)'(2)) >= {1'b0, cols_c};
  assign row_end = ({1'b0, rc_r} + (CW+1)'(2)) >= {1'b0, rws_c};
  assign grid_end = sh_r && col_end && row_end;

  always_comb begin
    cc_nxt = cc_r;
    rc_nxt = rc_r;
    sh_nxt = sh_r;
    sp_nxt = sp_r;
    ro_nxt = ro_r;
    last   = 1'b0;
    end_sh = 1'b0;
    push_job      = '0;
    push_job.kind = mtig_pkg::JOB_GRID;
    push_job.half = sh_r;
    push_job.col  = cc_r;
    push_job.row  = rc_r;
    push_job.cols = cols_c;
    push_job.cw   = cfg.clockwise;
    if (empty) begin
      push_job.kind = mtig_pkg::JOB_EMPTY;
      last   = 1'b1;
      end_sh = 1'b1;
    end else if (fan) begin
      push_job.kind = mtig_pkg::JOB_FAN;
      cc_nxt = cc_r + CW'(1);
      last   = col_end;
      end_sh = col_end;
    end else if (tube && (sp_r || (cols_c < CW'(2)))) begin
      push_job.kind = mtig_pkg::JOB_SEAM;
      last   = sh_r && row_end;
      end_sh = last;
      if (sh_r) begin
        sh_nxt = 1'b0;
        rc_nxt = rc_r + CW'(1);
      end else begin
        sh_nxt = 1'b1;
      end
    end else begin
      if (sh_r) begin
        sh_nxt = 1'b0;
        if (col_end) begin
          cc_nxt = '0;
          rc_nxt = rc_r + CW'(1);
        end else begin
          cc_nxt = cc_r + CW'(1);
        end
      end else begin
        sh_nxt = 1'b1;
      end
      if (grid_end) begin
        if (tube) begin
          // grid part done, seam triangles follow
          cc_nxt = '0;
          rc_nxt = '0;
          sh_nxt = 1'b0;
          sp_nxt = 1'b1;
        end else begin
          last   = 1'b1;
          end_sh = 1'b1;
        end
      end
    end
    push_job.last = last;
    if (end_sh) begin
      cc_nxt = '0;
      rc_nxt = '0;
      sh_nxt = 1'b0;
      sp_nxt = 1'b0;
      if (cfg.track_offset) begin
        ro_nxt = ro_adv;
      end
    end
    if (!emit) begin
      cc_nxt = cc_r;
      rc_nxt = rc_r;
      sh_nxt = sh_r;
      sp_nxt = sp_r;
      ro_nxt = ro_r;
    end
    if (load) begin
      ro_nxt = in_start_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      rc_r <= '0;
      sh_r <= 1'b0;
      sp_r <= 1'b0;
      ro_r <= '0;
    end else begin
      cc_r <= cc_nxt;
      rc_r <= rc_nxt;
      sh_r <= sh_nxt;
      sp_r <= sp_nxt;
      ro_r <= ro_nxt;
    end
  end

  a_load_keeps_walk: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> $stable(cc_r) && $stable(rc_r) && $stable(sh_r) && $stable(sp_r))
    else $error("offset load disturbed the shape counters");

endmodule

FILE: sv/mtig_back.sv
`timescale 1ns / 1ps
// back end: multiplies out the row base, forms the three vertex indices,
// applies winding and offset, and holds the result register; uses mtig_pkg

module mtig_back #(
  parameter int INDEX_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  mtig_pkg::job_t        q_job,
  input  logic [INDEX_BITS-1:0] q_off,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [INDEX_BITS-1:0] out_index_first,
  output logic [INDEX_BITS-1:0] out_index_second,
  output logic [INDEX_BITS-1:0] out_index_third,
  output logic                  out_shape_done,
  output logic                  out_empty_shape
);

  localparam int AW = mtig_pkg::ARITH_W;
  localparam int CW = mtig_pkg::CFG_W;

  // stage a: row base product
  logic                          a_valid_r;
  mtig_pkg::job_t                a_job_r;
  logic [INDEX_BITS-1:0]         a_off_r;
  logic [mtig_pkg::PROD_W-1:0]   a_prod_r;

  // output register
  logic                  out_valid_r;
  logic [INDEX_BITS-1:0] idx0_r, idx1_r, idx2_r;
  logic                  done_r, empty_r;

  logic          a_ready, b_ready;
  logic [AW-1:0] m, colw, w, p, off;
  logic [AW-1:0] ra, rb, rc, fa, fb, fc;

  assign b_ready = !out_valid_r || !out_stall;
  assign a_ready = !a_valid_r || b_ready;
  assign pop     = q_valid && a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_job_r  <= q_job;
      a_off_r  <= q_off;
      a_prod_r <= {{CW{1'b0}}, q_job.cols} * {{CW{1'b0}}, q_job.row};
    end
  end

  assign m    = AW'(a_prod_r);
  assign colw = AW'(a_job_r.cols);
  assign w    = AW'(a_job_r.col);
  assign p    = m + w;
  assign off  = (a_job_r.kind == mtig_pkg::JOB_EMPTY) ? '0 : AW'(a_off_r);

  always_comb begin
    case (a_job_r.kind)
      mtig_pkg::JOB_GRID: begin
        ra = p;
        rb = a_job_r.half ? p + colw + AW'(1) : p + colw;
        rc = a_job_r.half ? p + AW'(1) : p + colw + AW'(1);
      end
      mtig_pkg::JOB_SEAM: begin
        ra = a_job_r.half ? m + (colw << 1) - AW'(1) : m + colw - AW'(1);
        rb = a_job_r.half ? m + colw : m + (colw << 1) - AW'(1);
        rc = m;
      end
      mtig_pkg::JOB_FAN: begin
        ra = colw;
        rb = w;
        rc = w + AW'(1);
      end
      default: begin
        ra = '0;
        rb = '0;
        rc = '0;
      end
    endcase
    // counter-clockwise winding swaps the last two corners
    fa = ra + off;
    fb = (a_job_r.cw ? rb : rc) + off;
    fc = (a_job_r.cw ? rc : rb) + off;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_ready) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid_r) begin
      idx0_r  <= fa[INDEX_BITS-1:0];
      idx1_r  <= fb[INDEX_BITS-1:0];
      idx2_r  <= fc[INDEX_BITS-1:0];
      done_r  <= a_job_r.last;
      empty_r <= (a_job_r.kind == mtig_pkg::JOB_EMPTY);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_index_first  = idx0_r;
  assign out_index_second = idx1_r;
  assign out_index_third  = idx2_r;
  assign out_shape_done   = done_r;
  assign out_empty_shape  = empty_r;

  a_empty_is_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && empty_r |->
      done_r && (idx0_r == '0) && (idx1_r == '0) && (idx2_r == '0))
    else $error("empty shape result carries indices or misses shape end");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    a_valid_r && !b_ready |=> a_valid_r && $stable(a_job_r) && $stable(a_prod_r))
    else $error("product stage lost its job under back-pressure");

endmodule

FILE: bench/mesh_triangle_index_generator_test.sv
`timescale 1ns / 1ps
// self-checking bench for the mesh triangle index generator: directed shapes, back-pressure
// and randomized phases against an in-bench predictor; depends on mtig_pkg and the block rtl

module mesh_triangle_index_generator_test;

  localparam int IDX_W = 24;
  localparam int MAX_PTS = 256;
  localparam logic [31:0] IDX_MASK = (32'd1 << IDX_W) - 32'd1;
  localparam int DW = mtig_pkg::DATA_W;
  localparam int PAW = mtig_pkg::ADDR_W;

  // request codes on in_action
  localparam logic ACT_EMIT = 1'b0;
  localparam logic ACT_LOAD = 1'b1;
  // unused mode code, walked as a grid
  localparam logic [1:0] MODE_ALIAS = 2'd3;

  // cycles to let a load request settle before touching registers
  localparam int SETTLE_CYCLES = 10;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic             shape_done;
    logic             empty_shape;
  } triangle_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_valid = 1'b0;
  logic             in_stall;
  logic             in_action = ACT_EMIT;
  logic [IDX_W-1:0] in_start_offset = '0;

  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [IDX_W-1:0] out_index_first;
  logic [IDX_W-1:0] out_index_second;
  logic [IDX_W-1:0] out_index_third;
  logic             out_shape_done;
  logic             out_empty_shape;

  logic           psel = 1'b0;
  logic           penable = 1'b0;
  logic           pwrite = 1'b0;
  logic [PAW-1:0] paddr = '0;
  logic [DW-1:0]  pwdata = '0;
  logic [DW-1:0]  prdata;
  logic           pready;

  // register mirror, starting from the reset defaults
  logic [1:0] m_mode = mtig_pkg::MODE_GRID;
  logic [8:0] m_cols = 9'd2;
  logic [8:0] m_rows = 9'd2;
  logic       m_cw = 1'b1;
  logic       m_track = 1'b0;

  // walker state of the predictor
  logic [31:0] col_cnt = '0;
  logic [31:0] row_cnt = '0;
  logic        half_flag = 1'b0;
  logic        seam_flag = 1'b0;
  logic [31:0] run_offset = '0;

  triangle_t pending_triangles[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;

  // idling knobs, in percent per cycle
  int send_idle_pct = 0;
  int stall_pct = 0;
  // receiver hold-off request and its own countdown
  int hold_len = 0;
  int hold_cnt = 0;

  mesh_triangle_index_generator #(
    .MAX_POINTS(MAX_PTS),
    .INDEX_BITS(IDX_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_start_offset(in_start_offset),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_index_first(out_index_first),
    .out_index_second(out_index_second),
    .out_index_third(out_index_third),
    .out_shape_done(out_shape_done),
    .out_empty_shape(out_empty_shape),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // restart the walk; with tracking on the offset moves past this shape's vertices
  function automatic void close_shape(input logic [31:0] vcount);
    col_cnt = '0;
    row_cnt = '0;
    half_flag = 1'b0;
    seam_flag = 1'b0;
    if (m_track) run_offset = (run_offset + vcount) & IDX_MASK;
  endfunction

  // next triangle of the current shape; returns 0 when the item gives no result
  function automatic bit predict_triangle(input logic act, input logic [IDX_W-1:0] offs,
                                          output triangle_t res);
    logic [31:0] cols, rws, vcount, a, b, c, t, i, w, h, p;
    bit fan, tube, is_empty, is_last, grid_end;
    res = '0;
    a = '0;
    b = '0;
    c = '0;
    is_last = 1'b0;
    // load request only replaces the running offset
    if (act == ACT_LOAD) begin
      run_offset = {8'd0, offs};
      return 1'b0;
    end
    // oversized dimensions clamp to the point limit
    cols = (m_cols > MAX_PTS) ? MAX_PTS : 32'(m_cols);
    rws = (m_rows > MAX_PTS) ? MAX_PTS : 32'(m_rows);
    fan = (m_mode == mtig_pkg::MODE_FAN);
    tube = (m_mode == mtig_pkg::MODE_TUBE);
    vcount = fan ? cols + 32'd1 : cols * rws;
    if (fan) is_empty = cols < 2;
    else if (tube) is_empty = rws < 2;
    else is_empty = (cols < 2) || (rws < 2);
    if (is_empty) begin
      res.shape_done = 1'b1;
      res.empty_shape = 1'b1;
      close_shape(vcount);
      return 1'b1;
    end
    if (fan) begin
      // rim triangle around the centre point
      i = col_cnt;
      a = cols;
      b = i;
      c = i + 32'd1;
      is_last = (i + 32'd2 >= cols);
      col_cnt = col_cnt + 32'd1;
    end else if (tube && (seam_flag || cols < 2)) begin
      // seam between last and first column of two rows; may wrap below zero
      i = row_cnt;
      if (!half_flag) begin
        a = cols * (i + 32'd1) - 32'd1;
        b = cols * (i + 32'd2) - 32'd1;
        c = cols * i;
      end else begin
        a = cols * (i + 32'd2) - 32'd1;
        b = cols * (i + 32'd1);
        c = cols * i;
      end
      is_last = half_flag && (i + 32'd2 >= rws);
      if (half_flag) begin
        half_flag = 1'b0;
        row_cnt = row_cnt + 32'd1;
      end else begin
        half_flag = 1'b1;
      end
    end else begin
      // grid cell, two triangles per cell
      w = col_cnt;
      h = row_cnt;
      p = w + h * cols;
      grid_end = half_flag && (w + 32'd2 >= cols) && (h + 32'd2 >= rws);
      a = p;
      if (!half_flag) begin
        b = p + cols;
        c = p + cols + 32'd1;
      end else begin
        b = p + cols + 32'd1;
        c = p + 32'd1;
      end
      if (half_flag) begin
        half_flag = 1'b0;
        col_cnt = col_cnt + 32'd1;
        if (col_cnt + 32'd1 >= cols) begin
          col_cnt = '0;
          row_cnt = row_cnt + 32'd1;
        end
      end else begin
        half_flag = 1'b1;
      end
      if (grid_end) begin
        if (tube) begin
          col_cnt = '0;
          row_cnt = '0;
          half_flag = 1'b0;
          seam_flag = 1'b1;
        end else begin
          is_last = 1'b1;
        end
      end
    end
    // counter-clockwise swaps the last two corners
    if (!m_cw) begin
      t = b;
      b = c;
      c = t;
    end
    if (m_track) begin
      a = a + run_offset;
      b = b + run_offset;
      c = c + run_offset;
    end
    res.idx_a = a[IDX_W-1:0];
    res.idx_b = b[IDX_W-1:0];
    res.idx_c = c[IDX_W-1:0];
    res.shape_done = is_last;
    if (is_last) close_shape(vcount);
    return 1'b1;
  endfunction

  // offer one item, after a random idle gap, and record what it should give
  task automatic send_item(input logic act, input logic [IDX_W-1:0] offs);
    triangle_t res;
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_start_offset <= offs;
    // stall is stable mid-cycle, so sample it on the falling edge
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (predict_triangle(act, offs, res)) pending_triangles = {pending_triangles, res};
  endtask

  // stop offering and let every expected triangle come back
  task automatic wait_results_done;
    in_valid <= 1'b0;
    while (pending_triangles.size() != 0) @(posedge clk);
    // a trailing load request gives no result but may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // apb write: setup phase, access phase held until pready, then back to idle
  task automatic cfg_write(input logic [2:0] idx, input logic [DW-1:0] val);
    bit done;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      done = pready;
      @(posedge clk);
    end while (!done);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      mtig_pkg::REG_SHAPE_MODE:   m_mode = val[1:0];
      mtig_pkg::REG_COLUMNS:      m_cols = val[8:0];
      mtig_pkg::REG_ROWS:         m_rows = val[8:0];
      mtig_pkg::REG_CLOCKWISE:    m_cw = val[0];
      mtig_pkg::REG_TRACK_OFFSET: m_track = val[0];
      default: ;
    endcase
  endtask

  // reprogram the whole shape once the block is idle; the walk itself is not restarted
  task automatic set_shape(input logic [1:0] mode, input logic [8:0] cols,
                           input logic [8:0] rws, input logic cw, input logic track);
    wait_results_done();
    cfg_write(mtig_pkg::REG_SHAPE_MODE, DW'(mode));
    cfg_write(mtig_pkg::REG_COLUMNS, DW'(cols));
    cfg_write(mtig_pkg::REG_ROWS, DW'(rws));
    cfg_write(mtig_pkg::REG_CLOCKWISE, DW'(cw));
    cfg_write(mtig_pkg::REG_TRACK_OFFSET, DW'(track));
  endtask

  // mostly tiny dimensions so shapes finish, sometimes mid-sized or at the limits
  function automatic logic [8:0] pick_size;
    int r;
    r = $urandom_range(99);
    if (r < 75) return 9'($urandom_range(0, 6));
    if (r < 88) return 9'($urandom_range(7, 24));
    case ($urandom_range(3))
      0: return 9'd256;
      1: return 9'd257;
      2: return 9'd511;
      default: return 9'($urandom_range(0, 511));
    endcase
  endfunction

  task automatic random_shape;
    set_shape(2'($urandom_range(3)), pick_size(), pick_size(), 1'($urandom_range(1)),
              1'($urandom_range(1)));
  endtask

  // mostly emit requests; loads often land near the top to force index wrap
  task automatic random_item;
    logic [IDX_W-1:0] offs;
    if ($urandom_range(3) == 0) offs = IDX_W'(IDX_MASK) - IDX_W'($urandom_range(0, 500));
    else offs = IDX_W'($urandom);
    if ($urandom_range(99) < 12) send_item(ACT_LOAD, offs);
    else send_item(ACT_EMIT, offs);
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_cnt = hold_len;
      hold_len = 0;
    end
    if (hold_cnt != 0) begin
      out_stall <= 1'b1;
      hold_cnt--;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic note_mismatch(input string what, input triangle_t want, input triangle_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display({"mismatch (%s) at %0t: want %h %h %h done %b empty %b, ",
                "got %h %h %h done %b empty %b"},
               what, $realtime, want.idx_a, want.idx_b, want.idx_c, want.shape_done,
               want.empty_shape, got.idx_a, got.idx_b, got.idx_c, got.shape_done,
               got.empty_shape);
  endtask

  // result checker: a triangle taken at the next rising edge is compared here
  always @(negedge clk) begin
    triangle_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got.idx_a = out_index_first;
      got.idx_b = out_index_second;
      got.idx_c = out_index_third;
      got.shape_done = out_shape_done;
      got.empty_shape = out_empty_shape;
      if (pending_triangles.size() == 0) begin
        note_mismatch("no triangle expected", '0, got);
      end else begin
        want = pending_triangles.pop_front();
        if (got.idx_a !== want.idx_a || got.idx_b !== want.idx_b ||
            got.idx_c !== want.idx_c || got.shape_done !== want.shape_done ||
            got.empty_shape !== want.empty_shape)
          note_mismatch("wrong triangle", want, got);
      end
    end
  end

  // watchdog: too long without any item, result or register access
  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // default 2x2 grid straight out of reset: two triangles, then the walk restarts
  task automatic test_reset_defaults;
    repeat (3) send_item(ACT_EMIT, '0);
  endtask

  task automatic test_directed_shapes;
    // counter-clockwise grid with tracking, offset loaded just below the wrap point
    set_shape(mtig_pkg::MODE_GRID, 9'd3, 9'd2, 1'b0, 1'b1);
    send_item(ACT_LOAD, IDX_W'(IDX_MASK) - IDX_W'(1));
    repeat (4) send_item(ACT_EMIT, IDX_W'(IDX_MASK));
    // tube: one grid cell then the two seam triangles
    set_shape(mtig_pkg::MODE_TUBE, 9'd2, 9'd2, 1'b1, 1'b1);
    repeat (4) send_item(ACT_EMIT, '0);
    // tube with no columns goes straight to the seam, indices wrap below zero
    set_shape(mtig_pkg::MODE_TUBE, 9'd0, 9'd2, 1'b1, 1'b0);
    repeat (2) send_item(ACT_EMIT, '0);
    // fan of four rim points, counter-clockwise
    set_shape(mtig_pkg::MODE_FAN, 9'd4, 9'd0, 1'b0, 1'b0);
    repeat (2) send_item(ACT_EMIT, '0);
    // empty shapes: fan too small, grid of one row with clamped columns
    set_shape(mtig_pkg::MODE_FAN, 9'd1, 9'd9, 1'b1, 1'b1);
    send_item(ACT_EMIT, '0);
    set_shape(mtig_pkg::MODE_GRID, 9'd511, 9'd1, 1'b1, 1'b1);
    send_item(ACT_EMIT, '0);
    // the spare mode code walks as a grid; rows clamp to the limit
    set_shape(MODE_ALIAS, 9'd2, 9'd511, 1'b1, 1'b0);
    repeat (2) send_item(ACT_EMIT, '0);
  endtask

  // shrinking the columns mid-shape must still end the walk
  task automatic test_mid_shape_change;
    set_shape(mtig_pkg::MODE_GRID, 9'd4, 9'd4, 1'b1, 1'b0);
    repeat (3) send_item(ACT_EMIT, '0);
    wait_results_done();
    cfg_write(mtig_pkg::REG_COLUMNS, DW'(2));
    repeat (2) send_item(ACT_EMIT, '0);
  endtask

  task automatic test_backpressure;
    set_shape(mtig_pkg::MODE_GRID, 9'd5, 9'd4, 1'b1, 1'b1);
    send_idle_pct = 0;
    stall_pct = 0;
    // long receiver hold-off while the sender keeps pushing: queue fills, input stalls
    hold_len = HOLD_OFF_CYCLES;
    repeat (40) send_item(ACT_EMIT, IDX_W'($urandom));
    // sender pauses until every triangle is back, then resumes
    wait_results_done();
    repeat (20) send_item(ACT_EMIT, IDX_W'($urandom));
    wait_results_done();
    repeat (20) send_item(ACT_EMIT, IDX_W'($urandom));
  endtask

  task automatic run_random_phase(input int send_pct, input int stall_pct_v, input int count);
    wait_results_done();
    send_idle_pct = send_pct;
    stall_pct = stall_pct_v;
    for (int k = 0; k < count; k++) begin
      // new shape settings every so often, usually in the middle of a walk
      if (k % 90 == 0) random_shape();
      random_item();
    end
  endtask

  // idle mix per phase: none, sender only, receiver only, both
  task automatic test_random_phases;
    run_random_phase(0, 0, 460);
    run_random_phase(58, 0, 460);
    run_random_phase(0, 58, 460);
    run_random_phase(21, 21, 460);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_shapes();
    test_mid_shape_change();
    test_backpressure();
    test_random_phases();
    send_idle_pct = 0;
    stall_pct = 0;
    wait_results_done();
    if (mismatch_count == 0 && pending_triangles.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
